[hw/rtl/isq_pkg.sv]
// ----------------------------------------------------------------------------
// Ignition sequencer package
// Shared widths, register indexes, phase codes and the records that pass
// between the configuration block, the pass logic and the top level.
// ----------------------------------------------------------------------------
package isq_pkg;

	localparam int LEVEL_W     = 10;
	localparam int ELAPSED_W   = 10;
	localparam int COUNT_W     = 8;
	localparam int TIMER_W     = 16;
	localparam int PHASE_W     = 3;
	localparam int MANUAL_W    = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_INDEX_W = 2;

	localparam logic [LEVEL_W-1:0] THRESHOLD_RST = LEVEL_W'(400);
	localparam logic [COUNT_W-1:0] DEBOUNCE_RST  = COUNT_W'(20);
	localparam logic [TIMER_W-1:0] IGNITE_RST    = TIMER_W'(1000);
	localparam logic [TIMER_W-1:0] BURN_RST      = TIMER_W'(15000);

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_MASTER_TRIP,
		REG_DEBOUNCE_PASSES,
		REG_IGNITE_DELAY,
		REG_BURN_TIME
	} reg_idx_t;

	typedef enum logic [PHASE_W-1:0] {
		PH_IDLE,
		PH_IGNITE,
		PH_OPEN,
		PH_BURN,
		PH_CLOSE,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] master_trip_level;
		logic [COUNT_W-1:0] debounce_passes;
		logic [TIMER_W-1:0] ignite_delay_ms;
		logic [TIMER_W-1:0] burn_time_ms;
	} cfg_t;

	typedef struct packed {
		logic [LEVEL_W-1:0]   master_level;
		logic                 arm_button;
		logic                 fire_switch;
		logic                 valve_one_button;
		logic                 valve_two_button;
		logic [ELAPSED_W-1:0] elapsed_ms;
	} item_t;

	typedef struct packed {
		logic               stable_master;
		logic [COUNT_W-1:0] differ_count;
		logic               prev_arm;
		logic               prev_valve_one_btn;
		logic               prev_valve_two_btn;
		logic               arm_flag;
		logic               fire_flag;
		logic               igniter_flag;
		logic               aux_power_flag;
		logic               valve_one_state;
		logic               valve_two_state;
		phase_t             phase;
		logic [TIMER_W-1:0] phase_timer;
	} state_t;

	typedef struct packed {
		logic                valve_one_open;
		logic                valve_two_open;
		logic                armed;
		logic                firing;
		logic                igniter_on;
		logic                aux_power_on;
		logic                master_on;
		logic [PHASE_W-1:0]  sequence_phase;
		logic                buzz_master;
		logic                buzz_arm;
		logic                buzz_fire;
		logic [MANUAL_W-1:0] buzz_manual_count;
	} result_t;

	localparam state_t STATE_RST = '{
		stable_master:      1'b0,
		differ_count:       '0,
		prev_arm:           1'b0,
		prev_valve_one_btn: 1'b0,
		prev_valve_two_btn: 1'b0,
		arm_flag:           1'b0,
		fire_flag:          1'b0,
		igniter_flag:       1'b0,
		aux_power_flag:     1'b0,
		valve_one_state:    1'b0,
		valve_two_state:    1'b0,
		phase:              PH_IDLE,
		phase_timer:        '0
	};

endpackage

[hw/rtl/isq_cfg.sv]
// ----------------------------------------------------------------------------
// Ignition sequencer configuration registers
// Holds the master threshold, debounce count and the two sequence delays,
// written one at a time through a plain write port.
// ----------------------------------------------------------------------------
module isq_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [isq_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [isq_pkg::CFG_DATA_W-1:0]   cfg_data,
	output isq_pkg::cfg_t                    cfg
);

	isq_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.master_trip_level <= isq_pkg::THRESHOLD_RST;
			cfg_q.debounce_passes   <= isq_pkg::DEBOUNCE_RST;
			cfg_q.ignite_delay_ms   <= isq_pkg::IGNITE_RST;
			cfg_q.burn_time_ms      <= isq_pkg::BURN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				isq_pkg::REG_MASTER_TRIP: begin
					cfg_q.master_trip_level <= cfg_data[isq_pkg::LEVEL_W-1:0];
				end
				isq_pkg::REG_DEBOUNCE_PASSES: begin
					cfg_q.debounce_passes <= cfg_data[isq_pkg::COUNT_W-1:0];
				end
				isq_pkg::REG_IGNITE_DELAY: begin
					cfg_q.ignite_delay_ms <= cfg_data[isq_pkg::TIMER_W-1:0];
				end
				isq_pkg::REG_BURN_TIME: begin
					cfg_q.burn_time_ms <= cfg_data[isq_pkg::TIMER_W-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[hw/rtl/isq_step.sv]
// ----------------------------------------------------------------------------
// Ignition sequencer pass logic
// Computes the state after one control pass and the result of that pass:
// master debounce, arm toggle, fire start, sequence phases and manual abort.
// ----------------------------------------------------------------------------
module isq_step (
	input  isq_pkg::state_t  st,
	input  isq_pkg::cfg_t    cfg,
	input  isq_pkg::item_t   item,
	output isq_pkg::state_t  nxt,
	output isq_pkg::result_t res
);

	isq_pkg::state_t               n;
	logic [isq_pkg::TIMER_W:0]     timer_sum;
	logic [isq_pkg::COUNT_W-1:0]   cnt_inc;
	logic                          raw;
	logic                          buzz_master;
	logic                          buzz_arm;
	logic                          buzz_fire;
	logic [isq_pkg::MANUAL_W-1:0]  manual;

	always_comb begin
		n           = st;
		buzz_master = 1'b0;
		buzz_arm    = 1'b0;
		buzz_fire   = 1'b0;
		manual      = '0;

		// The timer runs on every pass and sticks at its maximum.
		timer_sum = {1'b0, st.phase_timer} +
			(isq_pkg::TIMER_W+1)'(item.elapsed_ms);
		n.phase_timer = timer_sum[isq_pkg::TIMER_W] ? isq_pkg::TIMER_MAX
			: timer_sum[isq_pkg::TIMER_W-1:0];

		raw     = item.master_level > cfg.master_trip_level;
		cnt_inc = (st.differ_count == isq_pkg::COUNT_MAX) ? st.differ_count
			: st.differ_count + isq_pkg::COUNT_W'(1);
		if (raw == st.stable_master) begin
			n.differ_count = '0;
		end else begin
			n.differ_count = cnt_inc;
			// A debounce setting of zero behaves as one, since cnt_inc is never zero here.
			if (cnt_inc >= cfg.debounce_passes) begin
				n.stable_master = raw;
				n.differ_count  = '0;
				buzz_master     = 1'b1;
			end
		end

		if (n.stable_master) begin
			n.aux_power_flag = 1'b1;
			if (item.arm_button && !st.prev_arm) begin
				n.arm_flag = !n.arm_flag;
				buzz_arm   = 1'b1;
			end
			if (!item.fire_switch && n.arm_flag && n.phase == isq_pkg::PH_IDLE) begin
				n.fire_flag = !n.fire_flag;
				if (n.fire_flag) begin
					buzz_fire      = 1'b1;
					n.igniter_flag = 1'b1;
					n.phase        = isq_pkg::PH_IGNITE;
					n.phase_timer  = '0;
				end
			end
		end else begin
			n.arm_flag     = 1'b0;
			n.igniter_flag = 1'b0;
			if (!n.fire_flag) begin
				n.aux_power_flag = 1'b0;
			end
		end
		n.prev_arm = item.arm_button;

		// A sequence started in this pass already checks its ignite delay here.
		case (n.phase)
			isq_pkg::PH_IGNITE: begin
				if (n.phase_timer >= cfg.ignite_delay_ms) begin
					n.valve_one_state = 1'b1;
					n.valve_two_state = 1'b1;
					n.phase           = isq_pkg::PH_OPEN;
				end
			end
			isq_pkg::PH_OPEN: begin
				n.phase       = isq_pkg::PH_BURN;
				n.phase_timer = '0;
			end
			isq_pkg::PH_BURN: begin
				if (n.phase_timer >= cfg.burn_time_ms) begin
					n.phase = isq_pkg::PH_CLOSE;
				end
			end
			isq_pkg::PH_CLOSE: begin
				n.valve_one_state = 1'b0;
				n.valve_two_state = 1'b0;
				n.phase           = isq_pkg::PH_DONE;
			end
			isq_pkg::PH_DONE: begin
				n.phase = isq_pkg::PH_IDLE;
			end
			default: begin
				n.phase = n.phase;
			end
		endcase

		if (n.stable_master) begin
			if (item.valve_one_button && !st.prev_valve_one_btn) begin
				n.valve_one_state = !n.valve_one_state;
				manual            = manual + isq_pkg::MANUAL_W'(1);
			end
			if (item.valve_two_button && !st.prev_valve_two_btn) begin
				n.valve_two_state = !n.valve_two_state;
				manual            = manual + isq_pkg::MANUAL_W'(1);
			end
			// Any manual valve action during a sequence aborts it.
			if (manual != '0 && n.phase != isq_pkg::PH_IDLE) begin
				n.phase           = isq_pkg::PH_IDLE;
				n.fire_flag       = 1'b0;
				n.igniter_flag    = 1'b0;
				n.valve_one_state = 1'b0;
				n.valve_two_state = 1'b0;
			end
		end
		n.prev_valve_one_btn = item.valve_one_button;
		n.prev_valve_two_btn = item.valve_two_button;
	end

	assign nxt = n;

	always_comb begin
		res.valve_one_open    = n.valve_one_state;
		res.valve_two_open    = n.valve_two_state;
		res.armed             = n.arm_flag;
		res.firing            = n.fire_flag;
		res.igniter_on        = n.igniter_flag;
		res.aux_power_on      = n.aux_power_flag;
		res.master_on         = n.stable_master;
		res.sequence_phase    = n.phase;
		res.buzz_master       = buzz_master;
		res.buzz_arm          = buzz_arm;
		res.buzz_fire         = buzz_fire;
		res.buzz_manual_count = manual;
	end

endmodule

[hw/rtl/ignition_sequencer_with_interlock_top.sv]
// ----------------------------------------------------------------------------
// Ignition sequencer with master interlock
// One control pass per input transfer: debounced master, arm and fire
// handling, six-phase ignition sequence and manual valve abort.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+--------------------------------
//   in      | to block  | in_valid / in_stall  | master_level .. elapsed_ms
//   out     | from block| out_valid / out_stall| valve_one_open .. buzz_manual_count
//   cfg     | to block  | cfg_we               | cfg_index, cfg_data
//
// One pass is accepted every clock unless an output stall holds the input side; its
// result is taken by the input register at the transfer and then by the result
// register behind the pass logic, which offers it to the output channel.
// The pass logic reads the state left by the previous pass in the same cycle,
// so back-to-back items see each other's updates with no bubble.
// Reset clears all flags, counters and the phase, and loads the register defaults.
// A stall on the output holds the result register and the input register; the
// input side stalls only while both are full.
// ----------------------------------------------------------------------------
module ignition_sequencer_with_interlock_top (
	input  logic                                 clk,
	input  logic                                 arst_n,

	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [isq_pkg::LEVEL_W-1:0]          master_level,
	input  logic                                 arm_button,
	input  logic                                 fire_switch,
	input  logic                                 valve_one_button,
	input  logic                                 valve_two_button,
	input  logic [isq_pkg::ELAPSED_W-1:0]        elapsed_ms,

	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 valve_one_open,
	output logic                                 valve_two_open,
	output logic                                 armed,
	output logic                                 firing,
	output logic                                 igniter_on,
	output logic                                 aux_power_on,
	output logic                                 master_on,
	output logic [isq_pkg::PHASE_W-1:0]          sequence_phase,
	output logic                                 buzz_master,
	output logic                                 buzz_arm,
	output logic                                 buzz_fire,
	output logic [isq_pkg::MANUAL_W-1:0]         buzz_manual_count,

	input  logic                                 cfg_we,
	input  logic [isq_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [isq_pkg::CFG_DATA_W-1:0]       cfg_data
);

	isq_pkg::cfg_t    cfg;
	isq_pkg::item_t   item_in;
	isq_pkg::item_t   item_s1;
	logic             valid_s1;
	isq_pkg::state_t  st_q;
	isq_pkg::state_t  st_nxt;
	isq_pkg::result_t res_nxt;
	isq_pkg::result_t res_q;
	logic             out_valid_q;
	logic             advance;

	isq_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign item_in.master_level     = master_level;
	assign item_in.arm_button       = arm_button;
	assign item_in.fire_switch      = fire_switch;
	assign item_in.valve_one_button = valve_one_button;
	assign item_in.valve_two_button = valve_two_button;
	assign item_in.elapsed_ms       = elapsed_ms;

	// The result register can take a new pass when it is empty or being drained.
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= item_in;
		end
	end

	isq_step u_step (
		.st   (st_q),
		.cfg  (cfg),
		.item (item_s1),
		.nxt  (st_nxt),
		.res  (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= isq_pkg::STATE_RST;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				st_q <= st_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid         = out_valid_q;
	assign valve_one_open    = res_q.valve_one_open;
	assign valve_two_open    = res_q.valve_two_open;
	assign armed             = res_q.armed;
	assign firing            = res_q.firing;
	assign igniter_on        = res_q.igniter_on;
	assign aux_power_on      = res_q.aux_power_on;
	assign master_on         = res_q.master_on;
	assign sequence_phase    = res_q.sequence_phase;
	assign buzz_master       = res_q.buzz_master;
	assign buzz_arm          = res_q.buzz_arm;
	assign buzz_fire         = res_q.buzz_fire;
	assign buzz_manual_count = res_q.buzz_manual_count;

	// A held input item must not change while the result register is blocked.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> valid_s1 && $stable(item_s1))
		else $error("input register changed while stalled");

	// A pass that moves into the result register is offered on the next cycle.
	a_pass_offered: assert property (@(posedge clk) disable iff (!arst_n)
		advance && valid_s1 |=> out_valid_q)
		else $error("transfer into result register lost");

	// The arm flag can only be set while the debounced master is on.
	a_arm_needs_master: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.arm_flag |-> st_q.stable_master)
		else $error("armed with master off");

	// The igniter is driven only while the debounced master is on.
	a_igniter_needs_master: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.igniter_flag |-> st_q.stable_master)
		else $error("igniter on with master off");

endmodule

[bench/tb_ignition_sequencer_with_interlock_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ignition sequencer with master interlock: block-level bench
// Drives control passes through the valid/stall input channel, predicts the
// debounce, arm, fire, sequence and manual valve behavior of every pass, and
// compares each result transfer field by field. Sender bursts and receiver
// stall patterns vary throughout; the registers are reloaded between phases.
// ----------------------------------------------------------------------------
module tb_ignition_sequencer_with_interlock_top;
	import isq_pkg::*;

	localparam int CYCLE_LIMIT = 200_000;

	typedef enum {STALL_NONE, STALL_PERIODIC, STALL_RANDOM, STALL_HEAVY} stall_mode_t;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic [LEVEL_W-1:0]     master_level = '0;
	logic                   arm_button = 1'b0;
	logic                   fire_switch = 1'b1;
	logic                   valve_one_button = 1'b0;
	logic                   valve_two_button = 1'b0;
	logic [ELAPSED_W-1:0]   elapsed_ms = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic                   valve_one_open;
	logic                   valve_two_open;
	logic                   armed;
	logic                   firing;
	logic                   igniter_on;
	logic                   aux_power_on;
	logic                   master_on;
	logic [PHASE_W-1:0]     sequence_phase;
	logic                   buzz_master;
	logic                   buzz_arm;
	logic                   buzz_fire;
	logic [MANUAL_W-1:0]    buzz_manual_count;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	class pass_tracker;
		logic [LEVEL_W-1:0] threshold    = THRESHOLD_RST;
		logic [COUNT_W-1:0] debounce     = DEBOUNCE_RST;
		logic [TIMER_W-1:0] ignite_delay = IGNITE_RST;
		logic [TIMER_W-1:0] burn_time    = BURN_RST;

		logic               master    = 1'b0;
		logic [COUNT_W-1:0] differ    = '0;
		logic               last_arm  = 1'b0;
		logic               last_v1   = 1'b0;
		logic               last_v2   = 1'b0;
		logic               arm_set   = 1'b0;
		logic               fire_set  = 1'b0;
		logic               igniter   = 1'b0;
		logic               aux       = 1'b0;
		logic               valve_one = 1'b0;
		logic               valve_two = 1'b0;
		phase_t             phase     = PH_IDLE;
		logic [TIMER_W-1:0] timer     = '0;

		result_t     awaited[$];
		int unsigned mismatches = 0;

		function void set_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_MASTER_TRIP:     threshold = data[LEVEL_W-1:0];
				REG_DEBOUNCE_PASSES: debounce = data[COUNT_W-1:0];
				REG_IGNITE_DELAY:    ignite_delay = data[TIMER_W-1:0];
				default:             burn_time = data[TIMER_W-1:0];
			endcase
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		// Works out the outcome of one accepted pass and queues it.
		function void note_pass(item_t p);
			result_t     r;
			int unsigned sum;
			logic        raw;
			r = '0;
			sum = timer + p.elapsed_ms;
			timer = (sum > 32'hFFFF) ? TIMER_MAX : sum[TIMER_W-1:0];

			raw = p.master_level > threshold;
			if (raw == master) begin
				differ = '0;
			end else begin
				if (differ != COUNT_MAX)
					differ = differ + 1'b1;
				if (differ >= debounce) begin
					master = raw;
					differ = '0;
					r.buzz_master = 1'b1;
				end
			end

			if (master) begin
				aux = 1'b1;
				if (p.arm_button && !last_arm) begin
					arm_set = !arm_set;
					r.buzz_arm = 1'b1;
				end
				if (!p.fire_switch && arm_set && phase == PH_IDLE) begin
					fire_set = !fire_set;
					if (fire_set) begin
						r.buzz_fire = 1'b1;
						igniter = 1'b1;
						phase = PH_IGNITE;
						timer = '0;
					end
				end
			end else begin
				arm_set = 1'b0;
				igniter = 1'b0;
				if (!fire_set)
					aux = 1'b0;
			end
			last_arm = p.arm_button;

			case (phase)
				PH_IGNITE: begin
					if (timer >= ignite_delay) begin
						valve_one = 1'b1;
						valve_two = 1'b1;
						phase = PH_OPEN;
					end
				end
				PH_OPEN: begin
					phase = PH_BURN;
					timer = '0;
				end
				PH_BURN: begin
					if (timer >= burn_time)
						phase = PH_CLOSE;
				end
				PH_CLOSE: begin
					valve_one = 1'b0;
					valve_two = 1'b0;
					phase = PH_DONE;
				end
				PH_DONE: phase = PH_IDLE;
				default: ;
			endcase

			// A manual valve toggle during an active sequence aborts it.
			if (master) begin
				if (p.valve_one_button && !last_v1) begin
					valve_one = !valve_one;
					r.buzz_manual_count = r.buzz_manual_count + 1'b1;
				end
				if (p.valve_two_button && !last_v2) begin
					valve_two = !valve_two;
					r.buzz_manual_count = r.buzz_manual_count + 1'b1;
				end
				if (r.buzz_manual_count != 0 && phase != PH_IDLE) begin
					phase = PH_IDLE;
					fire_set = 1'b0;
					igniter = 1'b0;
					valve_one = 1'b0;
					valve_two = 1'b0;
				end
			end
			last_v1 = p.valve_one_button;
			last_v2 = p.valve_two_button;

			r.valve_one_open = valve_one;
			r.valve_two_open = valve_two;
			r.armed          = arm_set;
			r.firing         = fire_set;
			r.igniter_on     = igniter;
			r.aux_power_on   = aux;
			r.master_on      = master;
			r.sequence_phase = phase;
			awaited.push_back(r);
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_pass(result_t got);
			result_t want;
			if (awaited.size() == 0) begin
				$error("result transfer with no pass outstanding");
				mismatches++;
				return;
			end
			want = awaited.pop_front();
			compare_field("valve_one_open", want.valve_one_open, got.valve_one_open);
			compare_field("valve_two_open", want.valve_two_open, got.valve_two_open);
			compare_field("armed", want.armed, got.armed);
			compare_field("firing", want.firing, got.firing);
			compare_field("igniter_on", want.igniter_on, got.igniter_on);
			compare_field("aux_power_on", want.aux_power_on, got.aux_power_on);
			compare_field("master_on", want.master_on, got.master_on);
			compare_field("sequence_phase", want.sequence_phase, got.sequence_phase);
			compare_field("buzz_master", want.buzz_master, got.buzz_master);
			compare_field("buzz_arm", want.buzz_arm, got.buzz_arm);
			compare_field("buzz_fire", want.buzz_fire, got.buzz_fire);
			compare_field("buzz_manual_count", want.buzz_manual_count,
				got.buzz_manual_count);
		endfunction
	endclass

	pass_tracker board = new;

	// Shape of the generated passes; the button levels persist between passes.
	bit          master_hi  = 1'b1;
	bit          arm_lvl    = 1'b0;
	bit          v1_lvl     = 1'b0;
	bit          v2_lvl     = 1'b0;
	int unsigned flip_pm    = 25;
	int unsigned valve_pm   = 30;
	int unsigned noise_pct  = 8;
	bit          long_steps = 1'b0;
	int unsigned burst_left = 0;
	int unsigned cycles     = 0;
	stall_mode_t stall_mode = STALL_NONE;
	int unsigned stall_hold = 0;
	int unsigned stall_tick = 0;

	function automatic item_t pass_of(int unsigned lvl, bit arm, bit fire, bit v1, bit v2,
		int unsigned ms);
		item_t p;
		p.master_level     = LEVEL_W'(lvl);
		p.arm_button       = arm;
		p.fire_switch      = fire;
		p.valve_one_button = v1;
		p.valve_two_button = v2;
		p.elapsed_ms       = ELAPSED_W'(ms);
		return p;
	endfunction

	function automatic item_t next_pass();
		item_t       p;
		int unsigned thr;
		int unsigned roll;
		thr = board.threshold;
		if ($urandom_range(0, 99) < noise_pct) begin
			p.master_level     = LEVEL_W'($urandom_range(0, 1023));
			p.arm_button       = 1'($urandom_range(0, 1));
			p.fire_switch      = 1'($urandom_range(0, 1));
			p.valve_one_button = 1'($urandom_range(0, 1));
			p.valve_two_button = 1'($urandom_range(0, 1));
			p.elapsed_ms       = ELAPSED_W'($urandom_range(0, 1023));
			return p;
		end
		if ($urandom_range(0, 999) < flip_pm)
			master_hi = !master_hi;
		if (master_hi && thr < 1023)
			p.master_level = LEVEL_W'($urandom_range(thr + 1, 1023));
		else if (master_hi)
			p.master_level = '1;
		else
			p.master_level = LEVEL_W'($urandom_range(0, thr));
		if ($urandom_range(0, 5) == 0)
			arm_lvl = !arm_lvl;
		if ($urandom_range(0, 999) < valve_pm)
			v1_lvl = !v1_lvl;
		if ($urandom_range(0, 999) < valve_pm)
			v2_lvl = !v2_lvl;
		p.arm_button       = arm_lvl;
		p.fire_switch      = ($urandom_range(0, 7) != 0);
		p.valve_one_button = v1_lvl;
		p.valve_two_button = v2_lvl;
		roll = $urandom_range(0, 99);
		if (long_steps)
			p.elapsed_ms = ELAPSED_W'($urandom_range(900, 1023));
		else if (roll < 12)
			p.elapsed_ms = '0;
		else if (roll < 24)
			p.elapsed_ms = '1;
		else if (roll < 60)
			p.elapsed_ms = ELAPSED_W'($urandom_range(0, 1023));
		else
			p.elapsed_ms = ELAPSED_W'($urandom_range(0, 300));
		return p;
	endfunction

	// Offers one pass and returns at the edge of its transfer.
	task automatic send_pass(input item_t p);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 24);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid         <= 1'b1;
		master_level     <= p.master_level;
		arm_button       <= p.arm_button;
		fire_switch      <= p.fire_switch;
		valve_one_button <= p.valve_one_button;
		valve_two_button <= p.valve_two_button;
		elapsed_ms       <= p.elapsed_ms;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_pass(p);
	endtask

	// Waits until every result is out, then writes all four registers.
	task automatic load_settings(input logic [LEVEL_W-1:0] thr, input logic [COUNT_W-1:0] deb,
		input logic [TIMER_W-1:0] ign, input logic [TIMER_W-1:0] burn);
		in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_MASTER_TRIP;
		cfg_data  <= CFG_DATA_W'(thr);
		@(posedge clk);
		cfg_index <= REG_DEBOUNCE_PASSES;
		cfg_data  <= CFG_DATA_W'(deb);
		@(posedge clk);
		cfg_index <= REG_IGNITE_DELAY;
		cfg_data  <= ign;
		@(posedge clk);
		cfg_index <= REG_BURN_TIME;
		cfg_data  <= burn;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_reg(REG_MASTER_TRIP, CFG_DATA_W'(thr));
		board.set_reg(REG_DEBOUNCE_PASSES, CFG_DATA_W'(deb));
		board.set_reg(REG_IGNITE_DELAY, ign);
		board.set_reg(REG_BURN_TIME, burn);
	endtask

	task automatic run_phase(input int unsigned thr, input int unsigned deb,
		input int unsigned ign, input int unsigned burn, input int unsigned n,
		input int unsigned flip, input int unsigned valve, input int unsigned noise,
		input bit long);
		load_settings(LEVEL_W'(thr), COUNT_W'(deb), TIMER_W'(ign), TIMER_W'(burn));
		flip_pm    = flip;
		valve_pm   = valve;
		noise_pct  = noise;
		long_steps = long;
		repeat (n) send_pass(next_pass());
	endtask

	ignition_sequencer_with_interlock_top i_dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin : receiver
		result_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.valve_one_open    = valve_one_open;
			got.valve_two_open    = valve_two_open;
			got.armed             = armed;
			got.firing            = firing;
			got.igniter_on        = igniter_on;
			got.aux_power_on      = aux_power_on;
			got.master_on         = master_on;
			got.sequence_phase    = sequence_phase;
			got.buzz_master       = buzz_master;
			got.buzz_arm          = buzz_arm;
			got.buzz_fire         = buzz_fire;
			got.buzz_manual_count = buzz_manual_count;
			board.check_pass(got);
		end
		if (stall_hold == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			stall_hold = $urandom_range(20, 120);
		end else begin
			stall_hold--;
		end
		stall_tick++;
		case (stall_mode)
			STALL_NONE:     out_stall <= 1'b0;
			STALL_PERIODIC: out_stall <= (stall_tick % 3 == 1);
			STALL_RANDOM:   out_stall <= 1'($urandom_range(0, 1));
			default:        out_stall <= ($urandom_range(0, 9) < 8);
		endcase
	end

	initial begin : stimulus
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero debounce acts like one; zero delays pass on the first check.
		load_settings(10'd500, 8'd0, 16'd0, 16'd0);
		send_pass(pass_of(1023, 0, 1, 0, 0, 1023));
		send_pass(pass_of(1023, 1, 1, 0, 0, 0));
		send_pass(pass_of(1023, 1, 0, 0, 0, 7));
		send_pass(pass_of(1023, 0, 1, 0, 0, 0));
		send_pass(pass_of(1023, 0, 1, 0, 0, 0));
		send_pass(pass_of(1023, 0, 1, 0, 0, 0));
		send_pass(pass_of(1023, 0, 1, 0, 0, 0));
		// The firing flag survives completion; the next requests toggle it.
		send_pass(pass_of(1023, 0, 0, 0, 0, 0));
		send_pass(pass_of(1023, 0, 0, 0, 0, 0));
		send_pass(pass_of(1023, 0, 1, 1, 0, 1023));
		send_pass(pass_of(1023, 0, 1, 1, 1, 0));
		send_pass(pass_of(1023, 0, 1, 0, 0, 0));
		send_pass(pass_of(1023, 0, 1, 1, 1, 0));
		send_pass(pass_of(1023, 0, 0, 0, 0, 0));
		// Master drops mid-sequence: arm and igniter clear, the sequence runs on.
		send_pass(pass_of(0, 0, 1, 0, 0, 1023));
		send_pass(pass_of(0, 0, 1, 0, 0, 0));
		send_pass(pass_of(0, 0, 1, 1, 1, 0));
		send_pass(pass_of(500, 0, 1, 0, 0, 0));
		send_pass(pass_of(501, 1, 1, 0, 0, 0));
		send_pass(pass_of(501, 1, 0, 0, 0, 0));
		send_pass(pass_of(501, 0, 0, 0, 0, 0));
		send_pass(pass_of(0, 0, 1, 0, 0, 0));

		run_phase(400, 20, 1000, 15000, 60, 25, 30, 6, 1'b0);
		run_phase(0, 1, 0, 0, 60, 40, 60, 8, 1'b0);
		run_phase(1023, 255, 65535, 65535, 40, 25, 30, 8, 1'b0);
		// Long debounce and maximum delays; the timer has to saturate to finish.
		master_hi = 1'b1;
		run_phase(100, 255, 65535, 65535, 420, 0, 2, 1, 1'b1);
		run_phase($urandom_range(200, 800), $urandom_range(1, 6), $urandom_range(0, 3000),
			$urandom_range(0, 5000), 120, 25, 40, 8, 1'b0);

		in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (board.mismatches == 0 && board.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
